// ===== src/alsp_pkg.sv =====
// Shared constants, widths and interface structs for the anti-aliased line stepper.
// Used by every module of the block; depends on nothing.
`default_nettype none

package alsp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = 13;
  localparam int SCALE_W    = 4;
  localparam int FB_W       = 14;
  localparam int PIX_W      = 16;
  localparam int COV_W      = 8;
  localparam int COORD_W    = 18;
  localparam int DX_W       = COORD_W - 1;
  localparam int QW         = FRAC_BITS + 1;
  localparam int GRAD_W     = QW + 1;
  localparam int MINOR_W    = COORD_W + FRAC_BITS;
  localparam int NUM_W      = DX_W + FRAC_BITS + 2;
  localparam int DEN_W      = DX_W + 1;
  localparam int DIV_CNT_W  = $clog2(QW + 1);
  localparam int FRAC1_W    = FRAC_BITS + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FB_W;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RST     = 4'd1;
  localparam logic [FB_W-1:0]    FB_WIDTH_RST  = 14'd640;
  localparam logic [FB_W-1:0]    FB_HEIGHT_RST = 14'd480;

  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  localparam logic [FRAC1_W-1:0] FRAC_ONE  = FRAC1_W'(1) << FRAC_BITS;
  localparam logic [FRAC1_W-1:0] FRAC_HALF = FRAC_ONE >> 1;

  typedef struct packed {
    logic                      steep;
    logic signed [COORD_W-1:0] major;
    logic signed [COORD_W-1:0] minor;
    logic [FRAC1_W-1:0]        frac;
  } plot_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [COV_W-1:0] cov;
    logic             in_fb;
  } plot_res_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

`default_nettype wire

// ===== src/alsp_div.sv =====
// Serial restoring divider, one quotient bit per cycle, for the line gradient.
// Depends on alsp_pkg.
`default_nettype none

module alsp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  alsp_pkg::div_req_t         req,
  output logic                       busy,
  output logic [alsp_pkg::QW-1:0]    quotient
);

  logic [alsp_pkg::DEN_W-1:0]     rem;
  logic [alsp_pkg::DEN_W-1:0]     den_r;
  logic [alsp_pkg::QW-1:0]        shreg;
  logic [alsp_pkg::DIV_CNT_W-1:0] cnt;
  logic [alsp_pkg::DEN_W:0]       cand;
  logic [alsp_pkg::DEN_W:0]       diff;
  logic                           q_bit;
  logic [alsp_pkg::DEN_W-1:0]     rem_next;

  assign cand     = {rem, shreg[alsp_pkg::QW-1]};
  assign diff     = cand - {1'b0, den_r};
  assign q_bit    = ~diff[alsp_pkg::DEN_W];
  assign rem_next = q_bit ? diff[alsp_pkg::DEN_W-1:0] : cand[alsp_pkg::DEN_W-1:0];
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= alsp_pkg::DIV_CNT_W'(alsp_pkg::QW);
    end else if (busy) begin
      cnt <= cnt - alsp_pkg::DIV_CNT_W'(1);
      if (cnt == alsp_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= req.num[alsp_pkg::NUM_W-1:alsp_pkg::QW];
      shreg <= req.num[alsp_pkg::QW-1:0];
      den_r <= req.den;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[alsp_pkg::QW-2:0], q_bit};
    end
  end

endmodule

`default_nettype wire

// ===== src/alsp_plot.sv =====
// Plot formatter: un-swaps major/minor to x/y, bounds check, fraction to coverage.
// Depends on alsp_pkg.
`default_nettype none

module alsp_plot (
  input  alsp_pkg::plot_req_t        req,
  input  logic [alsp_pkg::FB_W-1:0]  fb_width,
  input  logic [alsp_pkg::FB_W-1:0]  fb_height,
  output alsp_pkg::plot_res_t        res
);

  localparam int CW = alsp_pkg::FRAC1_W + alsp_pkg::COV_W;

  logic signed [alsp_pkg::COORD_W-1:0] x;
  logic signed [alsp_pkg::COORD_W-1:0] y;
  logic [CW-1:0]                       scaled;
  logic [CW-1:0]                       rounded;

  assign x = req.steep ? req.minor : req.major;
  assign y = req.steep ? req.major : req.minor;

  // f * 255 with round to nearest
  assign scaled  = {req.frac, alsp_pkg::COV_W'(0)} - CW'(req.frac);
  assign rounded = scaled + (CW'(1) << (alsp_pkg::FRAC_BITS - 1));

  assign res.x      = x[alsp_pkg::PIX_W-1:0];
  assign res.y      = y[alsp_pkg::PIX_W-1:0];
  assign res.cov    = rounded[alsp_pkg::FRAC_BITS +: alsp_pkg::COV_W];
  assign res.in_fb  = ~x[alsp_pkg::COORD_W-1] && ~y[alsp_pkg::COORD_W-1]
                   && (x[alsp_pkg::COORD_W-2:0] < (alsp_pkg::COORD_W-1)'(fb_width))
                   && (y[alsp_pkg::COORD_W-2:0] < (alsp_pkg::COORD_W-1)'(fb_height));

endmodule

`default_nettype wire

// ===== src/antialiased_line_stepper.sv =====
// Anti-aliased line stepper, top level: sequencer, line state and output register.
// Depends on alsp_pkg, alsp_div and alsp_plot.
//
// A begin beat is accepted, folds and orders the line, runs the serial gradient divider for
// its 17 quotient bits and waits to see it finish (skipped when both endpoints coincide),
// sets up the line state and then gives four output beats. A step beat is accepted and then
// gives its two output beats (one beat for a step with no active line). Output stall holds
// the output beats. The input is stalled from accept until the item's last output beat has
// been loaded into the output register.
`default_nettype none

module antialiased_line_stepper (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [alsp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [alsp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  req_type,
  input  logic signed [alsp_pkg::IN_W-1:0]      x_start,
  input  logic signed [alsp_pkg::IN_W-1:0]      y_start,
  input  logic signed [alsp_pkg::IN_W-1:0]      x_end,
  input  logic signed [alsp_pkg::IN_W-1:0]      y_end,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [alsp_pkg::PIX_W-1:0]     pixel_x,
  output logic signed [alsp_pkg::PIX_W-1:0]     pixel_y,
  output logic [alsp_pkg::COV_W-1:0]            coverage,
  output logic                                  inside_res,
  output logic                                  plot_valid,
  output logic                                  last
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FOLD  = 6'b000010,
    ST_ORDER = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_GRAD  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    MODE_BEGIN = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_NULL  = 2'd2
  } emit_mode_t;

  state_t     state, state_next;
  emit_mode_t emit_mode;
  logic [1:0] plot_idx;

  logic [alsp_pkg::SCALE_W-1:0] scale;
  logic [alsp_pkg::FB_W-1:0]    fb_width;
  logic [alsp_pkg::FB_W-1:0]    fb_height;

  logic line_active;
  logic steep;
  logic neg;
  logic degen;
  logic line_go;

  logic signed [alsp_pkg::COORD_W-1:0] p0x, p0y, p1x, p1y;
  logic [alsp_pkg::DX_W-1:0]           adx, ady;
  logic signed [alsp_pkg::COORD_W-1:0] column, final_column;
  logic signed [alsp_pkg::MINOR_W-1:0] minor_pos;
  logic signed [alsp_pkg::GRAD_W-1:0]  gradient;

  logic                                in_fire;
  logic                                emit_fire;
  logic                                emit_end;
  logic                                plot_real;
  logic                                plot_last;
  logic                                fin;

  logic [alsp_pkg::COORD_W-1:0]        adx_w, ady_w;
  logic                                steep_c;
  logic                                swap_c;
  logic [alsp_pkg::DX_W-1:0]           dx_c, ud_c;
  logic                                neg_c;
  logic [alsp_pkg::GRAD_W-1:0]         g_mag;
  logic [alsp_pkg::MINOR_W-1:0]        base;
  logic signed [alsp_pkg::COORD_W-1:0] fl;
  logic [alsp_pkg::FRAC_BITS-1:0]      fr;

  alsp_pkg::div_req_t            div_req;
  logic                          div_busy;
  logic [alsp_pkg::QW-1:0]       div_q;
  alsp_pkg::plot_req_t           preq;
  alsp_pkg::plot_res_t           pres;

  function automatic logic signed [alsp_pkg::COORD_W-1:0] scale_coord(
    input logic signed [alsp_pkg::IN_W-1:0] v,
    input logic [alsp_pkg::SCALE_W-1:0]     s
  );
    logic signed [alsp_pkg::COORD_W-1:0] a;
    logic signed [alsp_pkg::COORD_W-1:0] b;
    a = alsp_pkg::COORD_W'(v);
    b = $signed(alsp_pkg::COORD_W'(s));
    return a * b;
  endfunction

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign emit_fire = (state == ST_EMIT) && (!out_valid || !out_stall);

  // fold: absolute deltas and steepness
  assign adx_w   = (p1x > p0x) ? p1x - p0x : p0x - p1x;
  assign ady_w   = (p1y > p0y) ? p1y - p0y : p0y - p1y;
  assign steep_c = ady_w[alsp_pkg::DX_W-1:0] > adx_w[alsp_pkg::DX_W-1:0];

  // order: left to right, gradient operands
  assign swap_c = p0x > p1x;
  assign dx_c   = steep ? ady : adx;
  assign ud_c   = steep ? adx : ady;
  assign neg_c  = swap_c ? (p0y < p1y) : (p1y < p0y);

  assign div_req.start = (state == ST_ORDER) && (dx_c != '0);
  assign div_req.num   = alsp_pkg::NUM_W'({ud_c, (alsp_pkg::FRAC_BITS + 1)'(0)})
                       + alsp_pkg::NUM_W'(dx_c);
  assign div_req.den   = {dx_c, 1'b0};

  alsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign g_mag = degen ? alsp_pkg::GRAD_W'(alsp_pkg::FRAC_ONE) : alsp_pkg::GRAD_W'(div_q);
  assign base  = {p0y, alsp_pkg::FRAC_BITS'(0)};

  assign fl  = minor_pos[alsp_pkg::MINOR_W-1:alsp_pkg::FRAC_BITS];
  assign fr  = minor_pos[alsp_pkg::FRAC_BITS-1:0];
  assign fin = (column == final_column);

  always_comb begin
    preq.steep = steep;
    preq.major = '0;
    preq.minor = '0;
    preq.frac  = '0;
    plot_real  = 1'b0;
    plot_last  = 1'b0;
    emit_end   = 1'b1;
    unique case (emit_mode)
      MODE_BEGIN: begin
        preq.major = plot_idx[1] ? p1x : p0x;
        preq.minor = (plot_idx[1] ? p1y : p0y) + alsp_pkg::COORD_W'(plot_idx[0]);
        preq.frac  = plot_idx[0] ? '0 : alsp_pkg::FRAC_HALF;
        plot_real  = 1'b1;
        plot_last  = (&plot_idx) && !line_active;
        emit_end   = &plot_idx;
      end
      MODE_STEP: begin
        preq.major = column;
        preq.minor = fl + alsp_pkg::COORD_W'(plot_idx[0]);
        preq.frac  = plot_idx[0] ? alsp_pkg::FRAC1_W'(fr)
                                 : alsp_pkg::FRAC_ONE - alsp_pkg::FRAC1_W'(fr);
        plot_real  = 1'b1;
        plot_last  = plot_idx[0] && fin;
        emit_end   = plot_idx[0];
      end
      MODE_NULL: begin
        emit_end = 1'b1;
      end
      default: begin
        emit_end = 1'b1;
      end
    endcase
  end

  alsp_plot u_plot (
    .req       (preq),
    .fb_width  (fb_width),
    .fb_height (fb_height),
    .res       (pres)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (req_type == alsp_pkg::REQ_BEGIN) ? ST_FOLD : ST_EMIT;
        end
      end
      ST_FOLD:  state_next = ST_ORDER;
      ST_ORDER: state_next = (dx_c == '0) ? ST_GRAD : ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_GRAD;
        end
      end
      ST_GRAD:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire && emit_end) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      emit_mode   <= MODE_NULL;
      plot_idx    <= '0;
      line_active <= 1'b0;
      out_valid   <= 1'b0;
      scale       <= alsp_pkg::SCALE_RST;
      fb_width    <= alsp_pkg::FB_WIDTH_RST;
      fb_height   <= alsp_pkg::FB_HEIGHT_RST;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          alsp_pkg::REG_SCALE:     scale     <= cfg_data[alsp_pkg::SCALE_W-1:0];
          alsp_pkg::REG_FB_WIDTH:  fb_width  <= cfg_data;
          alsp_pkg::REG_FB_HEIGHT: fb_height <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        plot_idx <= '0;
        if (req_type == alsp_pkg::REQ_BEGIN) begin
          emit_mode <= MODE_BEGIN;
        end else begin
          emit_mode <= line_active ? MODE_STEP : MODE_NULL;
        end
      end
      if (state == ST_GRAD) begin
        line_active <= line_go;
      end
      if (emit_fire) begin
        plot_idx <= plot_idx + 2'd1;
        if (emit_mode == MODE_STEP && plot_idx[0] && fin) begin
          line_active <= 1'b0;
        end
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && req_type == alsp_pkg::REQ_BEGIN) begin
      p0x <= scale_coord(x_start, scale);
      p0y <= scale_coord(y_start, scale);
      p1x <= scale_coord(x_end, scale);
      p1y <= scale_coord(y_end, scale);
    end
    if (state == ST_FOLD) begin
      adx   <= adx_w[alsp_pkg::DX_W-1:0];
      ady   <= ady_w[alsp_pkg::DX_W-1:0];
      steep <= steep_c;
      if (steep_c) begin
        p0x <= p0y;
        p0y <= p0x;
        p1x <= p1y;
        p1y <= p1x;
      end
    end
    if (state == ST_ORDER) begin
      neg     <= neg_c;
      degen   <= (dx_c == '0);
      line_go <= (dx_c >= alsp_pkg::DX_W'(2));
      if (swap_c) begin
        p0x <= p1x;
        p0y <= p1y;
        p1x <= p0x;
        p1y <= p0y;
      end
    end
    if (state == ST_GRAD) begin
      gradient     <= neg ? -$signed(g_mag) : $signed(g_mag);
      minor_pos    <= neg ? base - alsp_pkg::MINOR_W'(g_mag) : base + alsp_pkg::MINOR_W'(g_mag);
      column       <= p0x + alsp_pkg::COORD_W'(1);
      final_column <= p1x - alsp_pkg::COORD_W'(1);
    end
    if (emit_fire && emit_mode == MODE_STEP && plot_idx[0]) begin
      column    <= column + alsp_pkg::COORD_W'(1);
      minor_pos <= minor_pos + alsp_pkg::MINOR_W'(gradient);
    end
    if (emit_fire) begin
      pixel_x    <= plot_real ? pres.x : '0;
      pixel_y    <= plot_real ? pres.y : '0;
      coverage   <= plot_real ? pres.cov : '0;
      inside_res <= plot_real && pres.in_fb;
      plot_valid <= plot_real;
      last       <= plot_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/alsp_checker.sv =====
// Port-level checks for the anti-aliased line stepper, bound to the top level.
// Depends on alsp_pkg and antialiased_line_stepper.
`default_nettype none

module alsp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [alsp_pkg::PIX_W-1:0]   pixel_x,
  input logic signed [alsp_pkg::PIX_W-1:0]   pixel_y,
  input logic [alsp_pkg::COV_W-1:0]          coverage,
  input logic                                inside_res,
  input logic                                plot_valid,
  input logic                                last
);

  // every accepted beat produces output, so the block is busy right after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  a_null_plot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !plot_valid |-> pixel_x == '0 && pixel_y == '0 && coverage == '0
                                 && !inside_res && !last)
    else $error("empty plot carries data");

  a_last_is_real: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> plot_valid)
    else $error("last on an empty plot");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
                               && $stable(coverage) && $stable(last))
    else $error("stalled output beat changed");

endmodule

bind antialiased_line_stepper alsp_checker u_alsp_checker (.*);

`default_nettype wire
